// ===== rtl/clge_pkg.sv =====
package clge_pkg;

  // instruction groups carried in the kind field
  typedef enum logic [2:0] {
    KIND_IMM   = 3'd0,
    KIND_MOVE  = 3'd1,
    KIND_AMEM  = 3'd2,
    KIND_STSP  = 3'd3,
    KIND_HLSP  = 3'd4,
    KIND_SPHL  = 3'd5,
    KIND_RDRET = 3'd6
  } kind_e;

  // address modes of the accumulator memory access
  typedef enum logic [2:0] {
    AM_BC   = 3'd0,
    AM_DE   = 3'd1,
    AM_HLI  = 3'd2,
    AM_HLD  = 3'd3,
    AM_A16  = 3'd4,
    AM_FFA8 = 3'd5,
    AM_FFC  = 3'd6
  } addr_mode_e;

  // memory request codes
  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_READ  = 2'd1,
    MEM_WRITE = 2'd2
  } mem_op_e;

  // register file indexes
  localparam logic [2:0] IDX_B = 3'd0;
  localparam logic [2:0] IDX_C = 3'd1;
  localparam logic [2:0] IDX_D = 3'd2;
  localparam logic [2:0] IDX_E = 3'd3;
  localparam logic [2:0] IDX_H = 3'd4;
  localparam logic [2:0] IDX_L = 3'd5;
  localparam logic [2:0] IDX_F = 3'd6;
  localparam logic [2:0] IDX_A = 3'd7;

  // r8 selector code for the (HL) operand
  localparam logic [2:0] SEL_HL = 3'd6;

  // pair code for the stack pointer in a wide immediate load
  localparam logic [1:0] PAIR_SP = 2'd3;

  // high page used by the FF00-relative modes
  localparam logic [7:0] HIGH_PAGE = 8'hFF;

  // M-cycle counts
  localparam logic [2:0] CYC_NONE = 3'd0;
  localparam logic [2:0] CYC_1    = 3'd1;
  localparam logic [2:0] CYC_2    = 3'd2;
  localparam logic [2:0] CYC_3    = 3'd3;
  localparam logic [2:0] CYC_4    = 3'd4;
  localparam logic [2:0] CYC_5    = 3'd5;

  typedef struct packed {
    logic [2:0]  kind;
    logic        wide;
    logic        direction;
    logic [2:0]  addr_mode;
    logic [2:0]  dst_sel;
    logic [2:0]  src_sel;
    logic [15:0] imm;
    logic [7:0]  read_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  mem_op;
    logic [15:0] mem_addr;
    logic [7:0]  mem_wdata;
    logic [2:0]  cycles;
    logic        last;
    logic [7:0]  reg_a;
    logic [3:0]  flags;
    logic [15:0] reg_hl;
    logic [15:0] reg_sp;
  } out_item_t;

  // control from the pipeline to the execute unit
  typedef struct packed {
    logic commit;
    logic second;
  } step_ctrl_t;

endpackage

// ===== rtl/clge_in_if.sv =====
interface clge_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic        wide;
  logic        direction;
  logic [2:0]  addr_mode;
  logic [2:0]  dst_sel;
  logic [2:0]  src_sel;
  logic [15:0] imm;
  logic [7:0]  read_data;

  modport source (
    output valid, kind, wide, direction, addr_mode, dst_sel, src_sel, imm, read_data,
    input  ready
  );

  modport sink (
    input  valid, kind, wide, direction, addr_mode, dst_sel, src_sel, imm, read_data,
    output ready
  );
endinterface

// ===== rtl/clge_out_if.sv =====
interface clge_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mem_op;
  logic [15:0] mem_addr;
  logic [7:0]  mem_wdata;
  logic [2:0]  cycles;
  logic        last;
  logic [7:0]  reg_a;
  logic [3:0]  flags;
  logic [15:0] reg_hl;
  logic [15:0] reg_sp;

  modport source (
    output valid, mem_op, mem_addr, mem_wdata, cycles, last, reg_a, flags, reg_hl, reg_sp,
    input  ready
  );

  modport sink (
    input  valid, mem_op, mem_addr, mem_wdata, cycles, last, reg_a, flags, reg_hl, reg_sp,
    output ready
  );
endinterface

// ===== rtl/clge_exec.sv =====
module clge_exec import clge_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_item_t   item_i,
  input  step_ctrl_t ctrl_i,
  output out_item_t  result_o
);

  // architectural state
  logic [7:0]  rf_q [8];
  logic [7:0]  rf_d [8];
  logic [15:0] sp_q, sp_d;
  logic        rd_pend_q, rd_pend_d;
  logic [2:0]  rd_tgt_q, rd_tgt_d;

  // operand helpers
  logic [15:0] hl;
  logic [15:0] hl_inc, hl_dec;
  logic [7:0]  ofs;
  logic [4:0]  nib_sum;
  logic [8:0]  byte_sum;
  logic [15:0] sp_ofs;
  logic [1:0]  pair;
  logic        amem_go;

  assign hl       = {rf_q[IDX_H], rf_q[IDX_L]};
  assign hl_inc   = hl + 16'd1;
  assign hl_dec   = hl - 16'd1;
  assign ofs      = item_i.imm[7:0];
  assign nib_sum  = {1'b0, sp_q[3:0]} + {1'b0, ofs[3:0]};
  assign byte_sum = {1'b0, sp_q[7:0]} + {1'b0, ofs};
  assign sp_ofs   = sp_q + {{8{ofs[7]}}, ofs};
  assign pair     = item_i.dst_sel[1:0];

  // one pass of the instruction: request fields and next state
  always_comb begin
    rf_d      = rf_q;
    sp_d      = sp_q;
    rd_pend_d = rd_pend_q;
    rd_tgt_d  = rd_tgt_q;
    amem_go   = 1'b1;

    result_o.mem_op    = MEM_NONE;
    result_o.mem_addr  = '0;
    result_o.mem_wdata = '0;
    result_o.cycles    = CYC_NONE;
    result_o.last      = 1'b1;

    case (item_i.kind)
      KIND_IMM: begin
        if (item_i.wide) begin
          if (pair == PAIR_SP) begin
            sp_d = item_i.imm;
          end else begin
            rf_d[{pair, 1'b0}] = item_i.imm[15:8];
            rf_d[{pair, 1'b1}] = item_i.imm[7:0];
          end
          result_o.cycles = CYC_3;
        end else if (item_i.dst_sel == SEL_HL) begin
          result_o.mem_op    = MEM_WRITE;
          result_o.mem_addr  = hl;
          result_o.mem_wdata = item_i.imm[7:0];
          result_o.cycles    = CYC_3;
        end else begin
          rf_d[item_i.dst_sel] = item_i.imm[7:0];
          result_o.cycles      = CYC_2;
        end
      end
      KIND_MOVE: begin
        if (item_i.dst_sel == SEL_HL && item_i.src_sel == SEL_HL) begin
          result_o.cycles = CYC_1;
        end else if (item_i.dst_sel == SEL_HL) begin
          result_o.mem_op    = MEM_WRITE;
          result_o.mem_addr  = hl;
          result_o.mem_wdata = rf_q[item_i.src_sel];
          result_o.cycles    = CYC_2;
        end else if (item_i.src_sel == SEL_HL) begin
          result_o.mem_op   = MEM_READ;
          result_o.mem_addr = hl;
          result_o.cycles   = CYC_2;
          rd_pend_d         = 1'b1;
          rd_tgt_d          = item_i.dst_sel;
        end else begin
          rf_d[item_i.dst_sel] = rf_q[item_i.src_sel];
          result_o.cycles      = CYC_1;
        end
      end
      KIND_AMEM: begin
        // address and cycle count by mode; the unused mode is a plain no-op
        case (item_i.addr_mode)
          AM_BC: begin
            result_o.mem_addr = {rf_q[IDX_B], rf_q[IDX_C]};
            result_o.cycles   = CYC_2;
          end
          AM_DE: begin
            result_o.mem_addr = {rf_q[IDX_D], rf_q[IDX_E]};
            result_o.cycles   = CYC_2;
          end
          AM_HLI: begin
            result_o.mem_addr = hl;
            result_o.cycles   = CYC_2;
            rf_d[IDX_H]       = hl_inc[15:8];
            rf_d[IDX_L]       = hl_inc[7:0];
          end
          AM_HLD: begin
            result_o.mem_addr = hl;
            result_o.cycles   = CYC_2;
            rf_d[IDX_H]       = hl_dec[15:8];
            rf_d[IDX_L]       = hl_dec[7:0];
          end
          AM_A16: begin
            result_o.mem_addr = item_i.imm;
            result_o.cycles   = CYC_4;
          end
          AM_FFA8: begin
            result_o.mem_addr = {HIGH_PAGE, item_i.imm[7:0]};
            result_o.cycles   = CYC_3;
          end
          AM_FFC: begin
            result_o.mem_addr = {HIGH_PAGE, rf_q[IDX_C]};
            result_o.cycles   = CYC_2;
          end
          default: begin
            amem_go         = 1'b0;
            result_o.cycles = CYC_1;
          end
        endcase
        if (amem_go) begin
          if (item_i.direction) begin
            result_o.mem_op = MEM_READ;
            rd_pend_d       = 1'b1;
            rd_tgt_d        = IDX_A;
          end else begin
            result_o.mem_op    = MEM_WRITE;
            result_o.mem_wdata = rf_q[IDX_A];
          end
        end
      end
      KIND_STSP: begin
        // low byte first, high byte on the second pass
        result_o.mem_op = MEM_WRITE;
        result_o.cycles = CYC_5;
        if (ctrl_i.second) begin
          result_o.mem_addr  = item_i.imm + 16'd1;
          result_o.mem_wdata = sp_q[15:8];
          result_o.last      = 1'b1;
        end else begin
          result_o.mem_addr  = item_i.imm;
          result_o.mem_wdata = sp_q[7:0];
          result_o.last      = 1'b0;
        end
      end
      KIND_HLSP: begin
        rf_d[IDX_H]     = sp_ofs[15:8];
        rf_d[IDX_L]     = sp_ofs[7:0];
        rf_d[IDX_F]     = {2'b00, nib_sum[4], byte_sum[8], 4'b0000};
        result_o.cycles = CYC_3;
      end
      KIND_SPHL: begin
        sp_d            = hl;
        result_o.cycles = CYC_2;
      end
      KIND_RDRET: begin
        if (rd_pend_q) begin
          rd_pend_d = 1'b0;
          if (rd_tgt_q == IDX_F) begin
            rf_d[rd_tgt_q] = {item_i.read_data[7:4], 4'b0000};
          end else begin
            rf_d[rd_tgt_q] = item_i.read_data;
          end
        end
      end
      default: begin
      end
    endcase

    // visible state after the step
    result_o.reg_a  = rf_d[IDX_A];
    result_o.flags  = rf_d[IDX_F][7:4];
    result_o.reg_hl = {rf_d[IDX_H], rf_d[IDX_L]};
    result_o.reg_sp = sp_d;
  end

  // state update when the instruction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_q      <= '{default: '0};
      sp_q      <= '0;
      rd_pend_q <= 1'b0;
      rd_tgt_q  <= '0;
    end else if (ctrl_i.commit) begin
      rf_q      <= rf_d;
      sp_q      <= sp_d;
      rd_pend_q <= rd_pend_d;
      rd_tgt_q  <= rd_tgt_d;
    end
  end

`ifndef SYNTHESIS
  // F never holds a low nibble
  assert property (@(posedge clk_i) disable iff (!rst_ni) rf_q[IDX_F][3:0] == 4'b0000)
    else $error("flag register low nibble set");

  // a read return consumes the pending read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.commit && item_i.kind == KIND_RDRET |=> !rd_pend_q)
    else $error("read still pending after return");

  // a read request leaves a read pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.commit && result_o.mem_op == MEM_READ |=> rd_pend_q)
    else $error("read request did not mark pending");
`endif

endmodule

// ===== rtl/cpu_load_group_executor_unit.sv =====
// Load instruction group executor for an 8-bit CPU core.
// Channels: in_i takes one load instruction per transaction (kind, operand
// selects, fetched immediate, or the byte of a memory read return); out_o
// gives one result per transaction: the memory request, the M-cycle count
// and A, flags, HL and SP as they stand after the instruction.
// A store of SP gives two results (low byte, then high byte, last on the
// second); every other instruction gives one.
// A transaction is registered in the input register, executed, and registered
// again in the result register before it is shown on out_o.
// Throughput: one instruction per cycle while the receiver takes results, set
// by the single execute pass between the input and result registers; a store
// of SP holds the input register for both of its passes.
// Reads are split: a read request marks a pending target, and a later
// read-return transaction writes the byte into it.
// Reset clears the register file, SP, the pending read and the valid flags of
// both pipeline registers. When the receiver stalls, the result register holds
// and in_i stays ready only while the input register is empty.
module cpu_load_group_executor_unit import clge_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  clge_in_if.sink           in_i,
  clge_out_if.source        out_o
);

  // pipeline registers
  in_item_t   in_q;
  logic       in_valid_q;
  logic       half_q;
  out_item_t  out_q;
  logic       out_valid_q;

  out_item_t  result;
  step_ctrl_t ctrl;
  logic       out_free;
  logic       step_fire;
  logic       consume;
  logic       split_first;
  logic       in_fire;

  // handshake control
  assign out_free    = !out_valid_q || out_o.ready;
  assign step_fire   = in_valid_q && out_free;
  assign split_first = (in_q.kind == KIND_STSP) && !half_q;
  assign consume     = step_fire && !split_first;
  assign in_i.ready  = !in_valid_q || consume;
  assign in_fire     = in_i.valid && in_i.ready;

  assign ctrl.commit = consume;
  assign ctrl.second = half_q;

  clge_exec u_exec (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (in_q),
    .ctrl_i   (ctrl),
    .result_o (result)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      half_q     <= 1'b0;
    end else begin
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (consume) begin
        in_valid_q <= 1'b0;
      end
      if (step_fire) begin
        half_q <= split_first;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q.kind      <= in_i.kind;
      in_q.wide      <= in_i.wide;
      in_q.direction <= in_i.direction;
      in_q.addr_mode <= in_i.addr_mode;
      in_q.dst_sel   <= in_i.dst_sel;
      in_q.src_sel   <= in_i.src_sel;
      in_q.imm       <= in_i.imm;
      in_q.read_data <= in_i.read_data;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      out_q <= result;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.mem_op    = out_q.mem_op;
  assign out_o.mem_addr  = out_q.mem_addr;
  assign out_o.mem_wdata = out_q.mem_wdata;
  assign out_o.cycles    = out_q.cycles;
  assign out_o.last      = out_q.last;
  assign out_o.reg_a     = out_q.reg_a;
  assign out_o.flags     = out_q.flags;
  assign out_o.reg_hl    = out_q.reg_hl;
  assign out_o.reg_sp    = out_q.reg_sp;

`ifndef SYNTHESIS
  // second half of a split store only exists with an instruction held
  assert property (@(posedge clk_i) disable iff (!rst_ni) half_q |-> in_valid_q)
    else $error("split store half without held instruction");

  // the first half of a store of SP is followed by its second half
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire && !consume |=> half_q && in_valid_q)
    else $error("split store lost its second half");

  // the second half always completes the instruction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    half_q && step_fire |-> consume)
    else $error("second half did not complete the instruction");

  // only the first half of a store of SP lacks last, and it is a write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.last |-> out_q.mem_op == MEM_WRITE && out_q.cycles == CYC_5)
    else $error("non-final result that is not a store of SP");
`endif

endmodule
